// ===== rtl/sha512_pkg.sv =====
// SHA-512 package: word type, initial hash values, round constants and sigma functions.
`timescale 1ns / 1ps
`default_nettype none

package sha512_pkg;

   typedef logic [63:0] word_type;

   localparam int unsigned NumHashWords = 8;
   localparam int unsigned WindowDepth  = 16;
   localparam logic [3:0]  LastWordPos  = 4'd15;
   localparam logic [6:0]  LastRound    = 7'd79;
   localparam logic [2:0]  LastDigestIx = 3'd7;

   localparam word_type InitHash [NumHashWords] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
      64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

   function automatic word_type round_const(input logic [6:0] idx);
      word_type k;
      case (idx)
         7'd0:  k = 64'h428a2f98d728ae22;
         7'd1:  k = 64'h7137449123ef65cd;
         7'd2:  k = 64'hb5c0fbcfec4d3b2f;
         7'd3:  k = 64'he9b5dba58189dbbc;
         7'd4:  k = 64'h3956c25bf348b538;
         7'd5:  k = 64'h59f111f1b605d019;
         7'd6:  k = 64'h923f82a4af194f9b;
         7'd7:  k = 64'hab1c5ed5da6d8118;
         7'd8:  k = 64'hd807aa98a3030242;
         7'd9:  k = 64'h12835b0145706fbe;
         7'd10: k = 64'h243185be4ee4b28c;
         7'd11: k = 64'h550c7dc3d5ffb4e2;
         7'd12: k = 64'h72be5d74f27b896f;
         7'd13: k = 64'h80deb1fe3b1696b1;
         7'd14: k = 64'h9bdc06a725c71235;
         7'd15: k = 64'hc19bf174cf692694;
         7'd16: k = 64'he49b69c19ef14ad2;
         7'd17: k = 64'hefbe4786384f25e3;
         7'd18: k = 64'h0fc19dc68b8cd5b5;
         7'd19: k = 64'h240ca1cc77ac9c65;
         7'd20: k = 64'h2de92c6f592b0275;
         7'd21: k = 64'h4a7484aa6ea6e483;
         7'd22: k = 64'h5cb0a9dcbd41fbd4;
         7'd23: k = 64'h76f988da831153b5;
         7'd24: k = 64'h983e5152ee66dfab;
         7'd25: k = 64'ha831c66d2db43210;
         7'd26: k = 64'hb00327c898fb213f;
         7'd27: k = 64'hbf597fc7beef0ee4;
         7'd28: k = 64'hc6e00bf33da88fc2;
         7'd29: k = 64'hd5a79147930aa725;
         7'd30: k = 64'h06ca6351e003826f;
         7'd31: k = 64'h142929670a0e6e70;
         7'd32: k = 64'h27b70a8546d22ffc;
         7'd33: k = 64'h2e1b21385c26c926;
         7'd34: k = 64'h4d2c6dfc5ac42aed;
         7'd35: k = 64'h53380d139d95b3df;
         7'd36: k = 64'h650a73548baf63de;
         7'd37: k = 64'h766a0abb3c77b2a8;
         7'd38: k = 64'h81c2c92e47edaee6;
         7'd39: k = 64'h92722c851482353b;
         7'd40: k = 64'ha2bfe8a14cf10364;
         7'd41: k = 64'ha81a664bbc423001;
         7'd42: k = 64'hc24b8b70d0f89791;
         7'd43: k = 64'hc76c51a30654be30;
         7'd44: k = 64'hd192e819d6ef5218;
         7'd45: k = 64'hd69906245565a910;
         7'd46: k = 64'hf40e35855771202a;
         7'd47: k = 64'h106aa07032bbd1b8;
         7'd48: k = 64'h19a4c116b8d2d0c8;
         7'd49: k = 64'h1e376c085141ab53;
         7'd50: k = 64'h2748774cdf8eeb99;
         7'd51: k = 64'h34b0bcb5e19b48a8;
         7'd52: k = 64'h391c0cb3c5c95a63;
         7'd53: k = 64'h4ed8aa4ae3418acb;
         7'd54: k = 64'h5b9cca4f7763e373;
         7'd55: k = 64'h682e6ff3d6b2b8a3;
         7'd56: k = 64'h748f82ee5defb2fc;
         7'd57: k = 64'h78a5636f43172f60;
         7'd58: k = 64'h84c87814a1f0ab72;
         7'd59: k = 64'h8cc702081a6439ec;
         7'd60: k = 64'h90befffa23631e28;
         7'd61: k = 64'ha4506cebde82bde9;
         7'd62: k = 64'hbef9a3f7b2c67915;
         7'd63: k = 64'hc67178f2e372532b;
         7'd64: k = 64'hca273eceea26619c;
         7'd65: k = 64'hd186b8c721c0c207;
         7'd66: k = 64'heada7dd6cde0eb1e;
         7'd67: k = 64'hf57d4f7fee6ed178;
         7'd68: k = 64'h06f067aa72176fba;
         7'd69: k = 64'h0a637dc5a2c898a6;
         7'd70: k = 64'h113f9804bef90dae;
         7'd71: k = 64'h1b710b35131c471b;
         7'd72: k = 64'h28db77f523047d84;
         7'd73: k = 64'h32caab7b40c72493;
         7'd74: k = 64'h3c9ebe0a15c9bebc;
         7'd75: k = 64'h431d67c49c100d4c;
         7'd76: k = 64'h4cc5d4becb3e42b6;
         7'd77: k = 64'h597f299cfc657e2a;
         7'd78: k = 64'h5fcb6fab3ad6faec;
         7'd79: k = 64'h6c44198c4a475817;
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sha512_if.sv =====
// Valid/ready channel interfaces for message words and digest words.
`timescale 1ns / 1ps
`default_nettype none

interface sha512_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] message_word;
   logic        first_of_message;
   logic        last_block;

   modport source (output valid, output message_word, output first_of_message,
                   output last_block, input ready);
   modport sink (input valid, input message_word, input first_of_message,
                 input last_block, output ready);
endinterface

interface sha512_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic [2:0]  digest_index;
   logic        last_word;

   modport source (output valid, output digest_word, output digest_index,
                   output last_word, input ready);
   modport sink (input valid, input digest_word, input digest_index,
                 input last_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/sha512_block_hasher_core.sv =====
// SHA-512 block hasher: word loader, iterative round unit and digest output buffer.
// Per 1024-bit block: 16 words loaded, 80 rounds and a chaining add; a final block then also
//   loads the digest buffer once the previous digest has drained; one round per cycle.
// The first digest word appears after the buffer load; no new words are taken before then.
// Digest words drain from their own buffer, so the next message loads meanwhile.
// Reset (synchronous): sequencer idle, counters cleared, chaining state set to the IV.
`timescale 1ns / 1ps
`default_nettype none

module sha512_block_hasher_core (
   input wire logic      clock,
   input wire logic      reset,
   sha512_req_if.sink    req_ch,
   sha512_rsp_if.source  rsp_ch
);
   import sha512_pkg::*;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ROUND,
      ST_CHAIN,
      ST_FLUSH
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] word_count_ff, word_count_in;
   logic [6:0] round_ff, round_in;
   logic       last_flag_ff, last_flag_in;
   logic       out_valid_ff, out_valid_in;
   logic [2:0] out_index_ff, out_index_in;

   word_type chain_ff  [NumHashWords];
   word_type chain_in  [NumHashWords];
   word_type vars_ff   [NumHashWords];
   word_type vars_in   [NumHashWords];
   word_type window_ff [WindowDepth];
   word_type window_in [WindowDepth];
   word_type out_buf_ff [NumHashWords];
   word_type out_buf_in [NumHashWords];

   word_type t1, t2, sched_next;
   logic     req_fire, rsp_fire;

   assign req_ch.ready        = (state_ff == ST_LOAD);
   assign req_fire            = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.digest_word  = out_buf_ff[0];
   assign rsp_ch.digest_index = out_index_ff;
   assign rsp_ch.last_word    = (out_index_ff == LastDigestIx);
   assign rsp_fire            = rsp_ch.valid && rsp_ch.ready;

   // shared round unit: window slot 0 holds W[t]
   always_comb begin
      t1 = vars_ff[7] + big_sigma1(vars_ff[4])
         + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
         + round_const(round_ff) + window_ff[0];
      t2 = big_sigma0(vars_ff[0])
         + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
            ^ (vars_ff[1] & vars_ff[2]));
      sched_next = small_sigma1(window_ff[14]) + window_ff[9]
                 + small_sigma0(window_ff[1]) + window_ff[0];
   end

   always_comb begin
      state_in      = state_ff;
      word_count_in = word_count_ff;
      round_in      = round_ff;
      last_flag_in  = last_flag_ff;
      out_valid_in  = out_valid_ff;
      out_index_in  = out_index_ff;
      chain_in      = chain_ff;
      vars_in       = vars_ff;
      window_in     = window_ff;
      out_buf_in    = out_buf_ff;

      // drain the digest buffer one item at a time
      if (rsp_fire) begin
         for (int i = 0; i < NumHashWords - 1; i++) begin
            out_buf_in[i] = out_buf_ff[i + 1];
         end
         out_index_in = out_index_ff + 3'd1;
         if (out_index_ff == LastDigestIx) begin
            out_valid_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               for (int i = 0; i < WindowDepth - 1; i++) begin
                  window_in[i] = window_ff[i + 1];
               end
               window_in[WindowDepth - 1] = req_ch.message_word;
               word_count_in = word_count_ff + 4'd1;
               if (word_count_ff == 4'd0 && req_ch.first_of_message) begin
                  for (int i = 0; i < NumHashWords; i++) begin
                     chain_in[i] = InitHash[i];
                  end
               end
               if (word_count_ff == LastWordPos) begin
                  vars_in      = chain_ff;
                  last_flag_in = req_ch.last_block;
                  round_in     = '0;
                  state_in     = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            vars_in[7] = vars_ff[6];
            vars_in[6] = vars_ff[5];
            vars_in[5] = vars_ff[4];
            vars_in[4] = vars_ff[3] + t1;
            vars_in[3] = vars_ff[2];
            vars_in[2] = vars_ff[1];
            vars_in[1] = vars_ff[0];
            vars_in[0] = t1 + t2;
            for (int i = 0; i < WindowDepth - 1; i++) begin
               window_in[i] = window_ff[i + 1];
            end
            window_in[WindowDepth - 1] = sched_next;
            round_in = round_ff + 7'd1;
            if (round_ff == LastRound) begin
               round_in = '0;
               state_in = ST_CHAIN;
            end
         end
         ST_CHAIN: begin
            for (int i = 0; i < NumHashWords; i++) begin
               chain_in[i] = chain_ff[i] + vars_ff[i];
            end
            state_in = last_flag_ff ? ST_FLUSH : ST_LOAD;
         end
         ST_FLUSH: begin
            // hold until the previous digest has fully drained
            if (!out_valid_ff) begin
               out_buf_in   = chain_ff;
               out_valid_in = 1'b1;
               out_index_in = '0;
               state_in     = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         word_count_ff <= '0;
         round_ff      <= '0;
         last_flag_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         out_index_ff  <= '0;
         for (int i = 0; i < NumHashWords; i++) begin
            chain_ff[i] <= InitHash[i];
         end
      end else begin
         state_ff      <= state_in;
         word_count_ff <= word_count_in;
         round_ff      <= round_in;
         last_flag_ff  <= last_flag_in;
         out_valid_ff  <= out_valid_in;
         out_index_ff  <= out_index_in;
         chain_ff      <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      vars_ff    <= vars_in;
      window_ff  <= window_in;
      out_buf_ff <= out_buf_in;
   end

endmodule

`default_nettype wire
